// File: hw/rtl/omce_pkg.sv
// Package for the ordered map ceiling extract block: sizes, operation codes
// and the structs passed between the top level and the row of table cells.
// No dependencies.
`default_nettype none

package omce_pkg;

    // Table size and field widths
    localparam int CAPACITY = 64;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int FUNC_W   = 2;

    // Operation codes; code 3 is unused and does nothing
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_RM_EQ = 2'd1,
        FUNC_RM_GE = 2'd2
    } t_func;

    // One table slot
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

    // Request held while the row works on it
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_cmd;

    // Row-wide shift controls
    typedef struct packed {
        logic ins;   // insert shifts the row right from the insert slot
        logic rem;   // remove shifts the row left from the hit slot
    } t_ctl;

endpackage : omce_pkg

`default_nettype wire

// File: hw/rtl/omce_ifs.sv
// Valid/ready channel interfaces for the request and response transactions.
// Depends on omce_pkg for field widths.
`default_nettype none

interface omce_req_if;
    import omce_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  item_value;

    modport source (output valid, output func, output key, output item_value, input ready);
    modport sink   (input valid, input func, input key, input item_value, output ready);
endinterface : omce_req_if

interface omce_rsp_if;
    import omce_pkg::*;
    logic             valid;
    logic             ready;
    logic             ok;
    logic [VAL_W-1:0] found_value;

    modport source (output valid, output ok, output found_value, input ready);
    modport sink   (input valid, input ok, input found_value, output ready);
endinterface : omce_rsp_if

`default_nettype wire

// File: hw/rtl/omce_cell.sv
// One slot of the sorted row: holds a key/value pair, compares it with the
// broadcast query and takes its left or right neighbor on a shift.
// Depends on omce_pkg.
`default_nettype none

module omce_cell
    import omce_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_cmd   i_cmd,
    input  wire t_ctl   i_ctl,
    input  wire t_slot  i_left_slot,
    input  wire         i_left_before,
    input  wire t_slot  i_right_slot,
    output t_slot       o_slot,
    output logic        o_before,
    output logic        o_hit
);

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    t_slot            n_slot;
    logic             w_pos;

    // Slot sorts before the query: at or below it for add (equal keys keep
    // arrival order), strictly below it for removals
    always_comb begin
        if (i_cmd.func == FUNC_ADD) begin
            o_before = r_valid && (r_key <= i_cmd.key);
        end else begin
            o_before = r_valid && (r_key < i_cmd.key);
        end
    end

    // First slot past the "before" prefix
    assign w_pos = !o_before && i_left_before;

    // Removal match at this slot
    assign o_hit = w_pos && r_valid &&
                   ((i_cmd.func == FUNC_RM_GE) ||
                    ((i_cmd.func == FUNC_RM_EQ) && (r_key == i_cmd.key)));

    assign o_slot = '{valid: r_valid, key: r_key, value: r_value};

    // Next slot contents
    always_comb begin
        n_slot = o_slot;
        if (i_ctl.ins && !o_before) begin
            if (w_pos) begin
                n_slot = '{valid: 1'b1, key: i_cmd.key, value: i_cmd.value};
            end else begin
                n_slot = i_left_slot;
            end
        end else if (i_ctl.rem && !o_before) begin
            n_slot = i_right_slot;
        end
    end

    // Valid bit is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        r_key   <= n_slot.key;
        r_value <= n_slot.value;
    end

endmodule : omce_cell

`default_nettype wire

// File: hw/rtl/ordered_map_ceiling_extract.sv
// Top level of the ordered map ceiling extract block: request register,
// row of omce_cell slots and response register.
// Depends on omce_pkg, omce_ifs (omce_req_if, omce_rsp_if) and omce_cell.
//
// Usage:
//   i_req carries one request per transaction: func (0 add, 1 remove equal
//   key, 2 remove least key at or above), key and item_value. o_rsp returns
//   one transaction per request: ok and found_value (zero on add or miss).
//   The table is a row of CAPACITY cells kept sorted by key, equal keys in
//   arrival order. A request is latched in the request register; all cells
//   compare against it at once, and once the response register is free
//   the row shifts by one slot on a successful add or removal and the
//   response register loads. A new request is taken only after the row is
//   done with the last one, set by the single request register in front of
//   the row (one request in the row at a time). When o_rsp stalls with a
//   response pending, the row holds the next request until the response
//   register frees, and i_req.ready stays low. Reset empties the table
//   (valid bits cleared) and drops any request or response in flight.
`default_nettype none

module ordered_map_ceiling_extract
    import omce_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    omce_req_if.sink     i_req,
    omce_rsp_if.source   o_rsp
);

    logic                r_busy;
    t_cmd                r_cmd;
    logic                r_out_valid;
    logic                r_ok;
    logic [VAL_W-1:0]    r_found;
    logic                n_ok;
    logic [VAL_W-1:0]    n_found;

    t_slot               w_slot   [CAPACITY];
    logic [CAPACITY-1:0] w_before;
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_valid;
    logic [VAL_W-1:0]    w_found;
    logic                w_any_hit;
    logic                w_full;
    logic                w_done;
    logic                w_accept;
    t_ctl                w_ctl;

    // Handshakes
    assign i_req.ready = !r_busy;
    assign w_accept    = i_req.valid && !r_busy;
    assign w_done      = r_busy && (!r_out_valid || o_rsp.ready);

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= '{func: i_req.func, key: i_req.key, value: i_req.item_value};
        end
    end

    // Row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_before;

        if (g == 0) begin : g_first
            assign w_left        = '0;
            assign w_left_before = 1'b1;
        end else begin : g_mid
            assign w_left        = w_slot[g-1];
            assign w_left_before = w_before[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_slot[g+1];
        end

        omce_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (r_cmd),
            .i_ctl        (w_ctl),
            .i_left_slot  (w_left),
            .i_left_before(w_left_before),
            .i_right_slot (w_right),
            .o_slot       (w_slot[g]),
            .o_before     (w_before[g]),
            .o_hit        (w_hit[g])
        );

        assign w_valid[g] = w_slot[g].valid;
    end

    // One-hot select of the removed value
    always_comb begin
        w_found = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_found = w_found | ({VAL_W{w_hit[i]}} & w_slot[i].value);
        end
    end

    assign w_any_hit = |w_hit;
    assign w_full    = w_valid[CAPACITY-1];

    // Shift controls and response
    always_comb begin
        w_ctl   = '0;
        n_ok    = 1'b0;
        n_found = '0;
        case (r_cmd.func)
            FUNC_ADD: begin
                w_ctl.ins = w_done && !w_full;
                n_ok      = !w_full;
            end
            FUNC_RM_EQ, FUNC_RM_GE: begin
                w_ctl.rem = w_done && w_any_hit;
                n_ok      = w_any_hit;
                n_found   = w_found;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_ok    <= n_ok;
            r_found <= n_found;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_ok;
    assign o_rsp.found_value = r_found;

`ifndef SYNTHESIS
    // Occupied slots always form a prefix of the row
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("occupied slots are not contiguous from slot zero");

    // At most one cell claims the removal
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell matched a removal");

    // A successful add grows the table by one entry
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && (r_cmd.func == FUNC_ADD) && !w_full) |=>
        ($countones(w_valid) == $past($countones(w_valid)) + 1))
        else $error("add did not grow the table by one");

    // A successful removal shrinks the table by one entry
    a_rem_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rem |=> ($countones(w_valid) + 1 == $past($countones(w_valid))))
        else $error("removal did not shrink the table by one");
`endif

endmodule : ordered_map_ceiling_extract

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for ordered_map_ceiling_extract: predicts each response
// from a software copy of the sorted table and drives both channels with random idling.
// Depends on omce_pkg, omce_ifs and the ordered_map_ceiling_extract RTL.
module tb;
    import omce_pkg::*;

    // Operation code 3 is not decoded by the block
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RSP_HOLD_CYCLES = 150;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] found_value;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    omce_req_if req_ch ();
    omce_rsp_if rsp_ch ();

    ordered_map_ceiling_extract DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the sorted table: ascending keys, equal keys oldest first
    logic [KEY_W-1:0] tbl_keys [CAPACITY];
    logic [VAL_W-1:0] tbl_vals [CAPACITY];
    int               tbl_count;

    t_outcome pending_outcomes [$];

    // Idling controls and the long receiver hold-off request
    bit send_idle;
    bit rsp_idle;
    bit rsp_hold;
    int add_pct;

    // Run statistics and failures
    int error_count;
    int adds_ok, adds_full, hits, misses, nops, peak_count, rsp_count;

    // Gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    // Applies one accepted request to the shadow table and queues its response
    function automatic void predict_request(input logic [FUNC_W-1:0] f,
                                            input logic [KEY_W-1:0]  k,
                                            input logic [VAL_W-1:0]  v);
        t_outcome res;
        int       pos;
        int       i;
        res = '0;
        if (f == FUNC_ADD) begin
            if (tbl_count < CAPACITY) begin
                // insert after any equal keys
                pos = 0;
                while (pos < tbl_count && tbl_keys[pos] <= k)
                    pos++;
                for (i = tbl_count; i > pos; i--) begin
                    tbl_keys[i] = tbl_keys[i-1];
                    tbl_vals[i] = tbl_vals[i-1];
                end
                tbl_keys[pos] = k;
                tbl_vals[pos] = v;
                tbl_count++;
                res.ok = 1'b1;
                adds_ok++;
                if (tbl_count > peak_count)
                    peak_count = tbl_count;
            end else begin
                adds_full++;
            end
        end else if (f == FUNC_RM_EQ || f == FUNC_RM_GE) begin
            // first slot at or above the query
            pos = 0;
            while (pos < tbl_count && tbl_keys[pos] < k)
                pos++;
            if (pos < tbl_count && (f == FUNC_RM_GE || tbl_keys[pos] == k)) begin
                res.ok          = 1'b1;
                res.found_value = tbl_vals[pos];
                for (i = pos; i + 1 < tbl_count; i++) begin
                    tbl_keys[i] = tbl_keys[i+1];
                    tbl_vals[i] = tbl_vals[i+1];
                end
                tbl_count--;
                hits++;
            end else begin
                misses++;
            end
        end else begin
            nops++;
        end
        pending_outcomes.push_back(res);
    endfunction

    // Key mix: extremes, full-width random, keys already stored or one below them and a small pool
    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0: k = '0;
            1: k = '1;
            2, 3: k = {$urandom, $urandom};
            4: k = {$urandom, $urandom} >> $urandom_range(0, 63);
            5, 6: begin
                if (tbl_count > 0)
                    k = tbl_keys[$urandom_range(0, tbl_count - 1)] - $urandom_range(0, 1);
                else
                    k = KEY_W'($urandom_range(0, 40));
            end
            default: k = KEY_W'($urandom_range(0, 40));
        endcase
        return k;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Operation mix leans on add_pct, raised toward adds while the table is nearly empty
    function automatic logic [FUNC_W-1:0] pick_func();
        int roll;
        int pct;
        roll = $urandom_range(0, 99);
        pct  = add_pct;
        if (tbl_count < 4 && pct < 60)
            pct = 60;
        if (roll < 4)
            return FUNC_UNUSED;
        if (roll < 4 + pct)
            return FUNC_ADD;
        return (roll % 2) ? FUNC_RM_EQ : FUNC_RM_GE;
    endfunction

    // Drops valid and keeps it low for the span given by n
    task automatic pause_sender(input int n);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Offers one request and waits for its transaction
    task automatic send_request(input logic [FUNC_W-1:0] f,
                                input logic [KEY_W-1:0]  k,
                                input logic [VAL_W-1:0]  v);
        @(negedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.func       <= f;
        req_ch.key        <= k;
        req_ch.item_value <= v;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        predict_request(f, k, v);
        if (send_idle && $urandom_range(0, 3) == 0)
            pause_sender(gap_len());
    endtask

    // Sender goes quiet until every predicted response is back
    task automatic wait_for_responses();
        pause_sender(1);
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: long hold-off on request, random stalls, or always ready
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold) begin
                rsp_hold = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge i_clk);
            end else if (rsp_idle && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap_len()) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Response checker: each transaction against the oldest prediction
    always @(posedge i_clk) begin : rsp_check
        t_outcome want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_count++;
            if (pending_outcomes.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected response: ok=%0b found_value=%h",
                             rsp_ch.ok, rsp_ch.found_value);
            end else begin
                want = pending_outcomes.pop_front();
                if (rsp_ch.ok !== want.ok || rsp_ch.found_value !== want.found_value) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch on response %0d: ok exp %0b got %0b, %s%h got %h",
                                 rsp_count, want.ok, rsp_ch.ok, "found_value exp ",
                                 want.found_value, rsp_ch.found_value);
                end
            end
        end
    end

    // Extremes, every operation, duplicates, misses, unused code, stored zero
    task automatic test_directed();
        send_request(FUNC_RM_EQ,  '0, '1);                  // remove from empty table
        send_request(FUNC_RM_GE,  '0, '0);
        send_request(FUNC_UNUSED, '1, '1);                  // unused code
        send_request(FUNC_ADD,    '0, '0);                  // stored value of zero
        send_request(FUNC_ADD,    '1, '1);
        send_request(FUNC_ADD,    64'd100, 64'hAAAA_0000_0000_0001);
        send_request(FUNC_ADD,    64'd100, 64'hBBBB_0000_0000_0002);
        send_request(FUNC_ADD,    64'd100, 64'hCCCC_0000_0000_0003);
        send_request(FUNC_RM_EQ,  64'd100, '0);             // oldest of equal keys
        send_request(FUNC_RM_GE,  64'd50,  '1);             // ceiling hit
        send_request(FUNC_RM_EQ,  64'd99,  '0);             // exact miss
        send_request(FUNC_RM_GE,  64'd101, '0);             // ceiling is the top key
        send_request(FUNC_RM_GE,  '1, '0);                  // ceiling miss
        send_request(FUNC_ADD,    64'h8000_0000_0000_0000, 64'd1);
        send_request(FUNC_RM_GE,  64'd1, '0);
        send_request(FUNC_RM_EQ,  '0, '1);                  // returns zero with ok
        send_request(FUNC_RM_GE,  64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_request(FUNC_UNUSED, '0, '0);
        send_request(FUNC_ADD,    '1, '0);
        send_request(FUNC_RM_EQ,  '1, '1);
        send_request(FUNC_ADD,    64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
        send_request(FUNC_ADD,    64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(FUNC_RM_GE,  64'h5555_5555_5555_5556, '0);
        send_request(FUNC_RM_GE,  '0, '0);
        wait_for_responses();
    endtask

    // Fill past capacity so adds are rejected, then drain in key order
    task automatic test_fill_and_drain();
        int n;
        send_idle = 1'b0;
        rsp_idle  = 1'b1;
        for (n = 0; n < CAPACITY + 4; n++)
            send_request(FUNC_ADD, rand_key(), rand_value());
        send_idle = 1'b1;
        for (n = 0; n < CAPACITY + 2; n++)
            send_request(FUNC_RM_GE, '0, rand_value());
        wait_for_responses();
    endtask

    // Receiver holds off long while requests keep coming, so the input stalls
    task automatic test_backpressure();
        int n;
        send_idle = 1'b0;
        add_pct   = 60;
        rsp_hold  = 1'b1;
        for (n = 0; n < 24; n++)
            send_request(pick_func(), rand_key(), rand_value());
        wait_for_responses();
    endtask

    // Random phases: filling, draining and balanced mixes, idling on and off
    task automatic test_random();
        int phase;
        int n;
        for (phase = 0; phase < 6; phase++) begin
            send_idle = phase[0];
            rsp_idle  = (phase % 3) != 0;
            case (phase % 3)
                0: add_pct = 80;
                1: add_pct = 48;
                default: add_pct = 20;
            endcase
            for (n = 0; n < 100; n++)
                send_request(pick_func(), rand_key(), rand_value());
        end
        wait_for_responses();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_ADD;
        req_ch.key        = '0;
        req_ch.item_value = '0;
        tbl_count   = 0;
        error_count = 0;
        send_idle   = 1'b1;
        rsp_idle    = 1'b1;
        rsp_hold    = 1'b0;
        add_pct     = 50;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_and_drain();
        test_backpressure();
        test_random();

        // let any stray response show up
        repeat (8) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            error_count += pending_outcomes.size();
            $display("%0d responses never arrived", pending_outcomes.size());
        end
        $display("covered %0d responses: %0d adds, %0d rejected on full table, %0d removals",
                 rsp_count, adds_ok, adds_full, hits);
        $display("  %0d removal misses, %0d unused codes, table peaked at %0d entries",
                 misses, nops, peak_count);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Run limit
    initial begin
        #5000000;
        $display("run limit reached with %0d responses outstanding", pending_outcomes.size());
        $display("tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/omce_pkg.sv
hw/rtl/omce_ifs.sv
hw/rtl/omce_cell.sv
hw/rtl/ordered_map_ceiling_extract.sv
bench/tb.sv
